@@ rtl/best_fit_buffer_pool_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Best-fit buffer pool unit: assertion macros
// Concurrent check macros shared by the RTL; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_BUFFER_POOL_UNIT_DEFINES_SVH
`define BEST_FIT_BUFFER_POOL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside of reset.
`define BFBP_ASSERT_HOLD(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("best_fit_buffer_pool_unit: check failed");
// Next-cycle implication, checked outside of reset.
`define BFBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("best_fit_buffer_pool_unit: check failed");
`else
`define BFBP_ASSERT_HOLD(label, clk, rst, ante, cons)
`define BFBP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/bfbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Best-fit buffer pool package
// Word types, command and status codes and constants of the pool unit.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam int ID_W          = 31;
  localparam int SIZE_W        = 31;
  localparam int SLOT_W        = 6;
  localparam int STATUS_W      = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [SIZE_W-1:0] SIZE_CEILING = 31'h7FFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] OWNER_PORT_RESET = 32'hFFFF_FFFF;

  // Command kinds.
  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_GET = 2'd1;
  localparam logic [1:0] REQ_REL = 2'd2;
  localparam logic [1:0] REQ_NOP = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_RECLAIMED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NONE          = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL          = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_UNKNOWN       = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_OWNER_PORT = 1'b0;
  localparam logic CFG_RECLAIM    = 1'b1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   buffer_id;
    logic              want_specific;
    logic [SIZE_W-1:0] size;
  } bfbp_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     granted_id;
    logic [SIZE_W-1:0]   granted_size;
    logic [SLOT_W-1:0]   slot_index;
  } bfbp_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } bfbp_state_t;

endpackage

@@ rtl/best_fit_buffer_pool_unit.sv @@
// ----------------------------------------------------------------------------
// Best-fit buffer pool unit
// Table of buffer entries with append, best-fit grant and release by id.
// ----------------------------------------------------------------------------
// A command word is taken at a clock edge where start is high and busy is low,
// and exactly one result word follows, shown on result for the single cycle in
// which done is high; the receiver cannot stall it, so it must take the word
// in that cycle. An add, a refused request, the unused command kind and any
// request or release against an empty table answer in the next cycle and leave
// busy low, so such words may follow back to back. A request or a release with
// n entries in the table walks all n slots through one read port of the entry
// memories and one size comparator; busy stays high through the scan and the
// done state, so no new word is taken before its result. The memories need no
// clearing pass: only slots below the entry count are ever read. Configuration
// writes are to be made while the unit is idle; the unit does not enforce this.
module best_fit_buffer_pool_unit #(
  parameter int SLOTS = bfbp_pkg::SLOTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  bfbp_pkg::bfbp_in_t                  cmd,
  output logic                                done,
  output bfbp_pkg::bfbp_out_t                 result,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [bfbp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bfbp_pkg::*;

  `include "best_fit_buffer_pool_unit_defines.svh"

  // Index width addresses the slots; count width can also hold SLOTS itself.
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  // Configuration registers.
  logic signed [CFG_DATA_W-1:0] owner_port;
  logic                         reclaim_pending;

  // Entry memories. The owner stamp only matters as "taken or free", so the
  // owner memory keeps one taken bit per slot.
  logic [ID_W-1:0]   mem_id    [SLOTS];
  logic [SIZE_W-1:0] mem_size  [SLOTS];
  logic              mem_taken [SLOTS];

  logic [CW-1:0]     entry_count;
  bfbp_state_t       state, state_next;
  bfbp_in_t          item;

  // Scan pipeline: read address, then registered read data under evaluation.
  logic [CW-1:0]     scan_addr;
  logic              rd_valid;
  logic              rd_last;
  logic [IW-1:0]     rd_idx;
  logic [ID_W-1:0]   rd_id;
  logic [SIZE_W-1:0] rd_size;
  logic              rd_taken;

  // Best candidate so far.
  logic              found;
  logic [IW-1:0]     best_idx;
  logic [ID_W-1:0]   best_id;
  logic [SIZE_W-1:0] best_size;

  logic accept;
  logic needs_scan;
  logic table_full;
  logic issue_rd;
  logic eval_en;
  logic finish;
  logic hit_get;
  logic hit_rel;
  logic take;
  logic add_wr;
  logic taken_we;
  logic [IW-1:0] taken_waddr;
  logic          taken_wdata;

  // Result word loaded at the accepting edge, and the one loaded when a scan
  // ends with a hit.
  bfbp_out_t accept_word;
  bfbp_out_t grant_word;

  assign accept     = start && !busy;
  assign table_full = (entry_count == SLOTS_C);
  assign needs_scan = (entry_count != '0) &&
                      (((cmd.req_type == REQ_GET) && !reclaim_pending) ||
                       (cmd.req_type == REQ_REL));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && needs_scan) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_valid && rd_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy     = 1'b1;
    issue_rd = 1'b0;
    eval_en  = 1'b0;
    finish   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SCAN: begin
        issue_rd = (scan_addr != entry_count);
        eval_en  = rd_valid;
      end
      ST_DONE: begin
        finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // The shared compare unit. A request keeps the strictly smaller fitting free
  // entry, so the lowest index wins among equal sizes; a release keeps the
  // first entry whose id matches, taken or not.
  assign hit_get = !rd_taken && (rd_size >= item.size) && (rd_size < best_size) &&
                   (!item.want_specific || (rd_id == item.buffer_id));
  assign hit_rel = !found && (rd_id == item.buffer_id);
  assign take    = eval_en && ((item.req_type == REQ_GET) ? hit_get : hit_rel);

  // Memory write control: an add fills a whole slot, a grant or release
  // updates only the taken bit. A grant with owner port zero leaves it free.
  assign add_wr      = accept && (cmd.req_type == REQ_ADD) && !table_full;
  assign taken_we    = add_wr || (finish && found);
  assign taken_waddr = finish ? best_idx : entry_count[IW-1:0];
  assign taken_wdata = finish && (item.req_type == REQ_GET) && (owner_port != '0);

  // Immediate answer of a newly accepted word. A scan that finds nothing keeps
  // this answer.
  always_comb begin
    accept_word = '0;
    unique case (cmd.req_type)
      REQ_ADD: begin
        if (table_full) begin
          accept_word.status = STAT_FULL;
        end else begin
          accept_word.status     = STAT_OK;
          accept_word.slot_index = SLOT_W'(entry_count[IW-1:0]);
        end
      end
      REQ_GET: begin
        if (reclaim_pending) begin
          accept_word.status = STAT_NOT_RECLAIMED;
        end else begin
          accept_word.status = STAT_NONE;
        end
      end
      REQ_REL: begin
        accept_word.status = STAT_UNKNOWN;
      end
      default: begin
        accept_word.status = STAT_OK;
      end
    endcase
  end

  // Answer of a scan that found a slot; only a grant reports id and size.
  always_comb begin
    grant_word            = '0;
    grant_word.status     = STAT_OK;
    grant_word.slot_index = SLOT_W'(best_idx);
    if (item.req_type == REQ_GET) begin
      grant_word.granted_id   = best_id;
      grant_word.granted_size = best_size;
    end
  end

  always_ff @(posedge clk) begin
    if (add_wr) begin
      mem_id[entry_count[IW-1:0]]   <= cmd.buffer_id;
      mem_size[entry_count[IW-1:0]] <= cmd.size;
    end
  end

  always_ff @(posedge clk) begin
    if (taken_we) begin
      mem_taken[taken_waddr] <= taken_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_rd) begin
      rd_id    <= mem_id[scan_addr[IW-1:0]];
      rd_size  <= mem_size[scan_addr[IW-1:0]];
      rd_taken <= mem_taken[scan_addr[IW-1:0]];
      rd_idx   <= scan_addr[IW-1:0];
      rd_last  <= (scan_addr == (entry_count - CW'(1)));
    end
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_port      <= OWNER_PORT_RESET;
      reclaim_pending <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWNER_PORT: owner_port      <= cfg_data;
        CFG_RECLAIM:    reclaim_pending <= cfg_data[0];
        default:        reclaim_pending <= reclaim_pending;
      endcase
    end
  end

  // Control state. A word that needs no scan answers in the next cycle; a
  // scan answers from the done state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      rd_valid    <= 1'b0;
      done        <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue_rd;
      done     <= (accept && !needs_scan) || finish;
      if (add_wr) begin
        entry_count <= entry_count + CW'(1);
      end
    end
  end

  // Scan bookkeeping and the result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= cmd;
      scan_addr <= '0;
      found     <= 1'b0;
      best_size <= SIZE_CEILING;
      result    <= accept_word;
    end else begin
      if (issue_rd) begin
        scan_addr <= scan_addr + CW'(1);
      end
      if (take) begin
        found     <= 1'b1;
        best_idx  <= rd_idx;
        best_id   <= rd_id;
        best_size <= rd_size;
      end
      if (finish && found) begin
        result <= grant_word;
      end
    end
  end

  // Checks.
  `BFBP_ASSERT_HOLD(a_count_bound, clk, rst, 1'b1, entry_count <= SLOTS_C)
  `BFBP_ASSERT_NEXT(a_full_add_keeps_count, clk, rst, accept && (cmd.req_type == REQ_ADD) && table_full, $stable(entry_count))
  `BFBP_ASSERT_NEXT(a_done_follows_finish, clk, rst, state == ST_DONE, done && (state == ST_IDLE))
  `BFBP_ASSERT_HOLD(a_quiet_while_scanning, clk, rst, state == ST_SCAN, !done && !accept)
  `BFBP_ASSERT_HOLD(a_grant_fits, clk, rst, done && (item.req_type == REQ_GET) && (result.status == STAT_OK), (result.granted_size >= item.size) && (result.granted_size != SIZE_CEILING))

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit buffer pool unit testbench
// Drives add, request, release and idle-kind command words into the pool
// unit in random bursts. Each accepted word is run through a behavioral copy
// of the pool table, and every result word is checked field by field against
// the oldest predicted reply.
// ----------------------------------------------------------------------------
module tb_top;
  import bfbp_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;

  // Random phases: length, share of add words (percent), owner stamp and
  // reclaim setting. An owner flagged as random is drawn when the phase opens.
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS [N_PHASES] = '{350, 300, 200, 250, 80, 220};
  localparam int PHASE_ADD_PCT [N_PHASES] = '{12, 20, 10, 15, 25, 10};
  localparam logic [31:0] PHASE_OWNER [N_PHASES] =
    '{32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0};
  localparam bit PHASE_OWNER_RANDOM [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam bit PHASE_RECLAIM [N_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  bfbp_in_t              cmd = '0;
  logic                  done;
  bfbp_out_t             result;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_OWNER_PORT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  best_fit_buffer_pool_unit #(
    .SLOTS(SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Behavioral copy of the pool table and of the two registers.
  logic [ID_W-1:0]       slot_id    [SLOTS];
  logic [SIZE_W-1:0]     slot_size  [SLOTS];
  logic [31:0]           slot_owner [SLOTS];
  int                    slot_used = 0;
  logic [CFG_DATA_W-1:0] owner_stamp = OWNER_PORT_RESET;
  logic                  reclaim_hold = 1'b0;

  // Command words waiting to be driven, and replies the pool still owes us.
  bfbp_in_t  cmd_backlog[$];
  bfbp_out_t owed_replies[$];

  int error_count = 0;
  int words_sent = 0;
  int setting_count = 0;
  int kind_count [4] = '{0, 0, 0, 0};
  int status_seen [8] = '{0, 0, 0, 0, 0, 0, 0, 0};
  int burst_left = 1;
  int gap_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the reply to one command word and apply its effect on the table.
  // A request picks the free slot of smallest size that still fits; the size
  // ceiling is excluded because a candidate must be strictly below it. Ties go
  // to the lowest slot because the comparison is strict.
  function automatic bfbp_out_t pool_reply(bfbp_in_t c);
    bfbp_out_t r;
    int n;
    int pick;
    logic [SIZE_W-1:0] pick_size;
    r = '0;
    n = (slot_used > SLOTS) ? SLOTS : slot_used;
    pick = -1;
    pick_size = SIZE_CEILING;
    case (c.req_type)
      REQ_ADD: begin
        if (n >= SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          slot_id[n] = c.buffer_id;
          slot_size[n] = c.size;
          slot_owner[n] = '0;
          slot_used = n + 1;
          r.status = STAT_OK;
          r.slot_index = SLOT_W'(n);
        end
      end
      REQ_GET: begin
        if (reclaim_hold) begin
          r.status = STAT_NOT_RECLAIMED;
        end else begin
          for (int i = 0; i < n; i++) begin
            if (slot_owner[i] == 0 && slot_size[i] >= c.size && slot_size[i] < pick_size &&
                (!c.want_specific || slot_id[i] == c.buffer_id)) begin
              pick = i;
              pick_size = slot_size[i];
            end
          end
          if (pick < 0) begin
            r.status = STAT_NONE;
          end else begin
            // An owner stamp of zero grants the slot but leaves it free.
            slot_owner[pick] = owner_stamp;
            r.status = STAT_OK;
            r.granted_id = slot_id[pick];
            r.granted_size = slot_size[pick];
            r.slot_index = SLOT_W'(pick);
          end
        end
      end
      REQ_REL: begin
        // The lowest matching slot is freed, even when it is free already.
        for (int i = 0; i < n; i++) begin
          if (pick < 0 && slot_id[i] == c.buffer_id) pick = i;
        end
        if (pick < 0) begin
          r.status = STAT_UNKNOWN;
        end else begin
          slot_owner[pick] = '0;
          r.status = STAT_OK;
          r.slot_index = SLOT_W'(pick);
        end
      end
      default: begin
        // The unused kind touches nothing and answers a plain ok.
        r.status = STAT_OK;
      end
    endcase
    return r;
  endfunction

  function automatic bfbp_in_t make_cmd(logic [1:0] kind, logic [ID_W-1:0] id, logic spec,
                                        logic [SIZE_W-1:0] sz);
    bfbp_in_t c;
    c.req_type = kind;
    c.buffer_id = id;
    c.want_specific = spec;
    c.size = sz;
    return c;
  endfunction

  // Ids come mostly from a small set so that releases and wanted-id requests
  // hit, and duplicates pile up; now and then a full-width id is thrown in.
  function automatic logic [ID_W-1:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return ID_W'($urandom_range(0, 15));
    if (roll < 90) return {ID_W{1'b1}};
    return ID_W'($urandom());
  endfunction

  // Sizes mostly sit in a narrow band so that best-fit choices compete, with
  // the extremes and full-width values mixed in.
  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return SIZE_W'($urandom_range(0, 40));
    if (roll < 80) return '0;
    if (roll < 85) return SIZE_CEILING;
    if (roll < 90) return SIZE_CEILING - SIZE_W'(1);
    return SIZE_W'($urandom());
  endfunction

  function automatic bfbp_in_t random_cmd(int add_pct);
    bfbp_in_t c;
    int roll;
    c.buffer_id = pick_id();
    c.size = pick_size();
    c.want_specific = ($urandom_range(0, 9) < 3);
    roll = $urandom_range(0, 99);
    if (roll < add_pct) c.req_type = REQ_ADD;
    else if (roll < add_pct + 46) c.req_type = REQ_GET;
    else if (roll < 97) c.req_type = REQ_REL;
    else c.req_type = REQ_NOP;
    return c;
  endfunction

  // Register writes happen only with the pool idle, so the model copy can be
  // updated at once.
  task automatic set_registers(logic [31:0] owner, logic reclaim);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OWNER_PORT;
    cfg_data <= owner;
    owner_stamp = owner;
    @(posedge clk);
    cfg_index <= CFG_RECLAIM;
    cfg_data <= {31'b0, reclaim};
    reclaim_hold = reclaim;
    @(posedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  // Wait until every queued word has been taken and answered, then let the
  // unit settle back to idle.
  task automatic drain_pool();
    while (cmd_backlog.size() != 0 || start || owed_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Driver. A word is taken at an edge where start is high and busy is low;
  // the prediction is made at that same edge. After a burst of random length
  // the driver pauses for a random gap, sometimes none, sometimes long enough
  // for the unit to fall idle. start gets at most one assignment per edge.
  always @(posedge clk) begin
    logic taken;
    taken = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        owed_replies.push_back(pool_reply(cmd));
        words_sent++;
        kind_count[cmd.req_type]++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 5))
            0, 1: gap_left = 0;
            2, 3, 4: gap_left = $urandom_range(1, 6);
            default: gap_left = $urandom_range(20, 90);
          endcase
        end
      end
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cmd <= cmd_backlog.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. A result word is valid only in the cycle where done is high,
  // and the receiver has no way to push back, so it is checked right there.
  always @(posedge clk) begin
    bfbp_out_t want;
    if (!rst && done) begin
      status_seen[result.status]++;
      if (owed_replies.size() == 0) begin
        $error("result word with no command outstanding: %0h", result);
        error_count++;
      end else begin
        want = owed_replies.pop_front();
        compare_field("status", 32'(want.status), 32'(result.status));
        compare_field("granted_id", 32'(want.granted_id), 32'(result.granted_id));
        compare_field("granted_size", 32'(want.granted_size), 32'(result.granted_size));
        compare_field("slot_index", 32'(want.slot_index), 32'(result.slot_index));
      end
    end
  end

  // Hard limit: the slowest legal run (every word a full-table scan after the
  // longest gap) stays below 3 ms, so 12 ms means the unit has hung.
  initial begin
    #12_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [31:0] owner;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part with reset settings. The empty table comes first: a
    // request and a release find nothing, and the idle kind answers ok.
    cmd_backlog.push_back(make_cmd(REQ_GET, 0, 1'b0, 0));
    cmd_backlog.push_back(make_cmd(REQ_REL, 3, 1'b0, 0));
    cmd_backlog.push_back(make_cmd(REQ_NOP, {ID_W{1'b1}}, 1'b1, {SIZE_W{1'b1}}));
    // Slots 0..5: zero size, the size ceiling, just below it, a tie at 20
    // and a second entry with id 3.
    cmd_backlog.push_back(make_cmd(REQ_ADD, 0, 1'b0, 0));
    cmd_backlog.push_back(make_cmd(REQ_ADD, {ID_W{1'b1}}, 1'b1, SIZE_CEILING));
    cmd_backlog.push_back(make_cmd(REQ_ADD, 5, 1'b0, SIZE_CEILING - SIZE_W'(1)));
    cmd_backlog.push_back(make_cmd(REQ_ADD, 3, 1'b0, 20));
    cmd_backlog.push_back(make_cmd(REQ_ADD, 4, 1'b0, 20));
    cmd_backlog.push_back(make_cmd(REQ_ADD, 3, 1'b0, 10));
    // The ceiling entry is never granted; the tie at 20 goes lowest first.
    cmd_backlog.push_back(make_cmd(REQ_GET, 0, 1'b0, SIZE_CEILING));
    cmd_backlog.push_back(make_cmd(REQ_GET, 0, 1'b0, 15));
    cmd_backlog.push_back(make_cmd(REQ_GET, 0, 1'b0, 15));
    cmd_backlog.push_back(make_cmd(REQ_GET, 3, 1'b1, 0));
    cmd_backlog.push_back(make_cmd(REQ_GET, 0, 1'b0, 0));
    cmd_backlog.push_back(make_cmd(REQ_GET, 0, 1'b0, 100));
    cmd_backlog.push_back(make_cmd(REQ_GET, {ID_W{1'b1}}, 1'b1, 0));
    // Duplicate id release twice (the second frees a free slot), then a miss.
    cmd_backlog.push_back(make_cmd(REQ_REL, 3, 1'b0, 0));
    cmd_backlog.push_back(make_cmd(REQ_REL, 3, 1'b1, 0));
    cmd_backlog.push_back(make_cmd(REQ_REL, 9, 1'b0, 0));
    drain_pool();

    // With an owner stamp of zero a grant leaves the slot free, so the same
    // slot is granted twice in a row.
    set_registers(32'h0, 1'b0);
    cmd_backlog.push_back(make_cmd(REQ_GET, 0, 1'b0, 1));
    cmd_backlog.push_back(make_cmd(REQ_GET, 0, 1'b0, 1));
    drain_pool();

    // Reclaim pending refuses requests but lets adds and releases through.
    set_registers(32'h0, 1'b1);
    cmd_backlog.push_back(make_cmd(REQ_GET, 0, 1'b0, 0));
    cmd_backlog.push_back(make_cmd(REQ_ADD, 6, 1'b0, 1));
    cmd_backlog.push_back(make_cmd(REQ_REL, 5, 1'b0, 0));
    drain_pool();

    // Random phases. The early ones keep the table partly filled for a
    // while; later it stays full and adds answer table full.
    for (int p = 0; p < N_PHASES; p++) begin
      owner = PHASE_OWNER[p];
      if (PHASE_OWNER_RANDOM[p]) owner = $urandom() & 32'h7FFF_FFFF;
      set_registers(owner, PHASE_RECLAIM[p]);
      for (int k = 0; k < PHASE_ITEMS[p]; k++) cmd_backlog.push_back(random_cmd(PHASE_ADD_PCT[p]));
      drain_pool();
    end

    // Wait past the longest scan for stray results.
    repeat (100) @(posedge clk);
    if (owed_replies.size() != 0) begin
      $error("%0d result words never arrived", owed_replies.size());
      error_count++;
    end

    $display("Covered %0d command words over %0d register settings: %0d adds, %0d requests,",
             words_sent, setting_count, kind_count[REQ_ADD], kind_count[REQ_GET]);
    $display("  %0d releases, %0d idle-kind; results: %0d ok, %0d reclaim-refused, %0d none, %0d full, %0d unknown",
             kind_count[REQ_REL], kind_count[REQ_NOP], status_seen[STAT_OK],
             status_seen[STAT_NOT_RECLAIMED], status_seen[STAT_NONE], status_seen[STAT_FULL],
             status_seen[STAT_UNKNOWN]);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
